/* rtl/core/slcp_pkg.sv */
// shared types, character codes and helpers of the slcan command line parser
package slcp_pkg;

   // frame layout
   localparam logic [4:0] STD_ID_NIBBLES = 5'd3;
   localparam logic [4:0] EXT_ID_NIBBLES = 5'd8;
   localparam int         MAX_DATA_BYTES = 8;
   localparam logic [4:0] POS_MAX        = 5'd31;
   localparam logic [7:0] LIMIT_RESET    = 8'd9;

   // ascii codes
   localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
   localparam logic [7:0] CHAR_UA   = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_LA   = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_UO   = 8'h4F;  // 'O'
   localparam logic [7:0] CHAR_UC   = 8'h43;  // 'C'
   localparam logic [7:0] CHAR_US   = 8'h53;  // 'S'
   localparam logic [7:0] CHAR_UM   = 8'h4D;  // 'M'
   localparam logic [7:0] CHAR_LM   = 8'h6D;  // 'm'
   localparam logic [7:0] CHAR_UV   = 8'h56;  // 'V'
   localparam logic [7:0] CHAR_UE   = 8'h45;  // 'E'
   localparam logic [7:0] CHAR_UT   = 8'h54;  // 'T'
   localparam logic [7:0] CHAR_LT   = 8'h74;  // 't'
   localparam logic [7:0] CHAR_UR   = 8'h52;  // 'R'
   localparam logic [7:0] CHAR_LR   = 8'h72;  // 'r'

   // command kinds
   localparam logic [2:0] KIND_OPEN      = 3'd0;
   localparam logic [2:0] KIND_CLOSE     = 3'd1;
   localparam logic [2:0] KIND_BITRATE   = 3'd2;
   localparam logic [2:0] KIND_MODE      = 3'd3;
   localparam logic [2:0] KIND_AUTORETRY = 3'd4;
   localparam logic [2:0] KIND_VERSION   = 3'd5;
   localparam logic [2:0] KIND_ERROR_RPT = 3'd6;
   localparam logic [2:0] KIND_TRANSMIT  = 3'd7;

   // line state as seen after the last byte is folded in
   typedef struct packed {
      logic [4:0]  position;
      logic [7:0]  letter;
      logic [31:0] id_acc;
      logic [7:0]  length_code;
      logic [63:0] data_store;
      logic [7:0]  first_arg;
   } line_state_type;

   // one result
   typedef struct packed {
      logic        status;
      logic [2:0]  command_kind;
      logic        extended_id;
      logic        remote_frame;
      logic [31:0] identifier;
      logic [3:0]  data_length;
      logic [63:0] payload;
      logic [7:0]  argument;
   } rsp_data_type;

   // unchecked hex digit conversion, mod 256
   function automatic logic [7:0] to_nibble(input logic [7:0] c);
      logic [7:0] r;
      if (c >= CHAR_LA)
         r = c - CHAR_LA + 8'd10;
      else if (c >= CHAR_UA)
         r = c - CHAR_UA + 8'd10;
      else
         r = c - CHAR_ZERO;
      return r;
   endfunction

   // extended identifier frame letters
   function automatic logic is_extended(input logic [7:0] letter);
      return (letter == CHAR_UT) || (letter == CHAR_UR);
   endfunction

endpackage

/* rtl/core/slcp_if.sv */
// request and response channel interfaces of the slcan command line parser
interface slcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       line_end;

   modport source (output valid, output char_byte, output line_end, input ready);
   modport sink   (input valid, input char_byte, input line_end, output ready);
endinterface

interface slcp_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [2:0]  command_kind;
   logic        extended_id;
   logic        remote_frame;
   logic [31:0] identifier;
   logic [3:0]  data_length;
   logic [63:0] payload;
   logic [7:0]  argument;

   modport source (output valid, output status, output command_kind, output extended_id,
                   output remote_frame, output identifier, output data_length,
                   output payload, output argument, input ready);
   modport sink   (input valid, input status, input command_kind, input extended_id,
                   input remote_frame, input identifier, input data_length,
                   input payload, input argument, output ready);
endinterface

/* rtl/core/slcp_finish.sv */
// result decode of a completed command line
module slcp_finish (
   input  slcp_pkg::line_state_type line_state,
   input  logic [7:0]               limit,
   output slcp_pkg::rsp_data_type   rsp_data
);

   logic       ext;
   logic [4:0] idn;
   logic [4:0] got;
   logic [4:0] missing;
   logic [6:0] shamt;
   logic [3:0] dlc;
   logic [63:0] mask;

   // identifier alignment for short lines
   always_comb begin
      ext     = slcp_pkg::is_extended(line_state.letter);
      idn     = ext ? slcp_pkg::EXT_ID_NIBBLES : slcp_pkg::STD_ID_NIBBLES;
      got     = (line_state.position < idn) ? line_state.position : idn;
      missing = idn - got;
      shamt   = {missing, 2'b00};
      dlc     = line_state.length_code[3:0];
      for (int b = 0; b < 8; b++) begin
         mask[8*b +: 8] = (4'(b) < dlc) ? 8'hFF : 8'h00;
      end
   end

   // command decode
   always_comb begin
      rsp_data = '0;
      unique case (line_state.letter) inside
         slcp_pkg::CHAR_UO: begin
            rsp_data.command_kind = slcp_pkg::KIND_OPEN;
         end
         slcp_pkg::CHAR_UC: begin
            rsp_data.command_kind = slcp_pkg::KIND_CLOSE;
         end
         slcp_pkg::CHAR_US: begin
            rsp_data.command_kind = slcp_pkg::KIND_BITRATE;
            rsp_data.argument     = line_state.first_arg;
            rsp_data.status       = (line_state.first_arg >= limit);
         end
         slcp_pkg::CHAR_LM, slcp_pkg::CHAR_UM: begin
            rsp_data.command_kind = slcp_pkg::KIND_MODE;
            rsp_data.argument     = {7'd0, line_state.first_arg == 8'd1};
         end
         slcp_pkg::CHAR_LA, slcp_pkg::CHAR_UA: begin
            rsp_data.command_kind = slcp_pkg::KIND_AUTORETRY;
            rsp_data.argument     = {7'd0, line_state.first_arg == 8'd1};
         end
         slcp_pkg::CHAR_UV: begin
            rsp_data.command_kind = slcp_pkg::KIND_VERSION;
         end
         slcp_pkg::CHAR_UE: begin
            rsp_data.command_kind = slcp_pkg::KIND_ERROR_RPT;
         end
         slcp_pkg::CHAR_LT, slcp_pkg::CHAR_UT, slcp_pkg::CHAR_LR, slcp_pkg::CHAR_UR: begin
            rsp_data.command_kind = slcp_pkg::KIND_TRANSMIT;
            rsp_data.extended_id  = ext;
            rsp_data.remote_frame = (line_state.letter == slcp_pkg::CHAR_LR) ||
                                    (line_state.letter == slcp_pkg::CHAR_UR);
            rsp_data.identifier   = line_state.id_acc << shamt;
            if (line_state.length_code > 8'(slcp_pkg::MAX_DATA_BYTES)) begin
               rsp_data.status = 1'b1;
            end else begin
               rsp_data.data_length = dlc;
               rsp_data.payload     = line_state.data_store & mask;
            end
         end
         default: begin
            rsp_data.status = 1'b1;
         end
      endcase
   end

endmodule

/* rtl/core/slcan_command_line_parser.sv */
// top level of the slcan ascii command line parser
// Takes one command byte per cycle, letter first, with line_end on the last byte,
// and gives one response per line. A request goes through an input register, its
// byte is folded into the line state, and the result for the last byte of a line
// is taken into the response register. The only stall is a line-end byte meeting
// a response register that has not been taken yet.
module slcan_command_line_parser (
   input  logic        clock,
   input  logic        reset,
   slcp_req_if.sink    req_chan,
   slcp_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_char_ff;
   logic        s1_end_ff;
   logic        s1_advance;
   logic        s1_fire;
   logic        req_fire;

   logic [7:0]  limit_ff;
   logic [4:0]  pos_ff, pos_in;
   logic [7:0]  letter_ff, letter_in;
   logic [31:0] id_ff, id_in;
   logic [7:0]  length_ff, length_in;
   logic [63:0] data_ff, data_in;
   logic [7:0]  high_ff, high_in;
   logic [7:0]  first_ff, first_in;

   logic [7:0]  nib;
   logic [4:0]  idn;
   logic [4:0]  k;
   logic [2:0]  j;
   logic [7:0]  new_byte;

   slcp_pkg::line_state_type upd_state;
   slcp_pkg::rsp_data_type   fin_data;
   slcp_pkg::rsp_data_type   rsp_data_ff;
   logic                     rsp_valid_ff, rsp_valid_in;

   // handshake
   assign s1_advance     = !s1_end_ff || !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire        = s1_valid_ff && s1_advance;
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign s1_valid_in    = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_fire) begin
         s1_char_ff <= req_chan.char_byte;
         s1_end_ff  <= req_chan.line_end;
      end
   end

   // fold the byte into the line state
   always_comb begin
      nib       = slcp_pkg::to_nibble(s1_char_ff);
      idn       = slcp_pkg::is_extended(letter_ff) ? slcp_pkg::EXT_ID_NIBBLES
                                                   : slcp_pkg::STD_ID_NIBBLES;
      k         = pos_ff - idn - 5'd2;
      j         = k[3:1];
      new_byte  = k[0] ? ({high_ff[3:0], 4'b0000} + nib) : {nib[3:0], 4'b0000};
      letter_in = letter_ff;
      id_in     = id_ff;
      length_in = length_ff;
      data_in   = data_ff;
      high_in   = high_ff;
      first_in  = first_ff;
      if (pos_ff == 5'd0) begin
         letter_in = s1_char_ff;
      end else begin
         if (pos_ff == 5'd1) begin
            first_in = nib;
         end
         if (pos_ff <= idn) begin
            id_in = {id_ff[27:0], 4'b0000} + {24'd0, nib};
         end else if (pos_ff == idn + 5'd1) begin
            length_in = nib;
         end else if (k < 5'(2 * slcp_pkg::MAX_DATA_BYTES)) begin
            if (!k[0]) begin
               high_in = nib;
            end
            for (int b = 0; b < slcp_pkg::MAX_DATA_BYTES; b++) begin
               if (j == 3'(b)) begin
                  data_in[8*b +: 8] = new_byte;
               end
            end
         end
      end
      pos_in = (pos_ff < slcp_pkg::POS_MAX) ? pos_ff + 5'd1 : pos_ff;
   end

   // line state as the result sees it
   always_comb begin
      upd_state.position    = pos_ff;
      upd_state.letter      = letter_in;
      upd_state.id_acc      = id_in;
      upd_state.length_code = length_in;
      upd_state.data_store  = data_in;
      upd_state.first_arg   = first_in;
   end

   slcp_finish u_finish (
      .line_state (upd_state),
      .limit      (limit_ff),
      .rsp_data   (fin_data)
   );

   // line state registers, cleared at the end of each line
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         letter_ff <= '0;
         id_ff     <= '0;
         length_ff <= '0;
         data_ff   <= '0;
         high_ff   <= '0;
         first_ff  <= '0;
      end else if (s1_fire) begin
         if (s1_end_ff) begin
            pos_ff    <= '0;
            letter_ff <= '0;
            id_ff     <= '0;
            length_ff <= '0;
            data_ff   <= '0;
            high_ff   <= '0;
            first_ff  <= '0;
         end else begin
            pos_ff    <= pos_in;
            letter_ff <= letter_in;
            id_ff     <= id_in;
            length_ff <= length_in;
            data_ff   <= data_in;
            high_ff   <= high_in;
            first_ff  <= first_in;
         end
      end
   end

   // bitrate limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= slcp_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // response register
   assign rsp_valid_in = (s1_fire && s1_end_ff) ? 1'b1
                                                : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_fire && s1_end_ff) begin
         rsp_data_ff <= fin_data;
      end
   end

   // response channel
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_data_ff.status;
   assign rsp_chan.command_kind = rsp_data_ff.command_kind;
   assign rsp_chan.extended_id  = rsp_data_ff.extended_id;
   assign rsp_chan.remote_frame = rsp_data_ff.remote_frame;
   assign rsp_chan.identifier   = rsp_data_ff.identifier;
   assign rsp_chan.data_length  = rsp_data_ff.data_length;
   assign rsp_chan.payload      = rsp_data_ff.payload;
   assign rsp_chan.argument     = rsp_data_ff.argument;

endmodule

/* tb/tb_slcan_command_line_parser.sv */
// testbench of the slcan command line parser: directed and random command lines checked against a predictor
`timescale 1ns / 100ps

module tb_slcan_command_line_parser;

   localparam int STALL_LIMIT = 4000;
   localparam int PRINT_LIMIT = 40;

   typedef struct {
      logic [7:0] code;
      logic       last;
   } line_char_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [7:0] csr_wr_data;

   slcp_req_if req_chan ();
   slcp_rsp_if rsp_chan ();

   slcan_command_line_parser i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // bytes waiting to be sent and commands waiting to come back
   line_char_type          line_bytes[$];
   slcp_pkg::rsp_data_type parsed_commands[$];

   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count;
   int idle_cycles;

   // predictor copy of the line state and the bitrate limit
   logic [4:0]  char_pos;
   logic [7:0]  cmd_letter;
   logic [31:0] id_acc;
   logic [7:0]  dlc_code;
   logic [63:0] data_acc;
   logic [7:0]  hi_nib;
   logic [7:0]  arg_nib;
   logic [7:0]  rate_limit;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void clear_line();
      char_pos   = '0;
      cmd_letter = '0;
      id_acc     = '0;
      dlc_code   = '0;
      data_acc   = '0;
      hi_nib     = '0;
      arg_nib    = '0;
   endfunction

   // digit value of a byte, no range check, wraps at 8 bits
   function automatic logic [7:0] hex_value(input logic [7:0] c);
      logic [7:0] base;
      if (c >= slcp_pkg::CHAR_LA)
         base = slcp_pkg::CHAR_LA;
      else if (c >= slcp_pkg::CHAR_UA)
         base = slcp_pkg::CHAR_UA;
      else
         base = slcp_pkg::CHAR_ZERO;
      return (base == slcp_pkg::CHAR_ZERO) ? c - slcp_pkg::CHAR_ZERO : c - base + 8'd10;
   endfunction

   function automatic logic wide_id(input logic [7:0] l);
      return (l == slcp_pkg::CHAR_UT) || (l == slcp_pkg::CHAR_UR);
   endfunction

   // command decoded from the line state at its last byte
   function automatic slcp_pkg::rsp_data_type finish_command();
      slcp_pkg::rsp_data_type r;
      logic [4:0]  id_len;
      logic [4:0]  got;
      logic [63:0] mask;
      r = '0;
      case (cmd_letter)
         slcp_pkg::CHAR_UO: r.command_kind = slcp_pkg::KIND_OPEN;
         slcp_pkg::CHAR_UC: r.command_kind = slcp_pkg::KIND_CLOSE;
         slcp_pkg::CHAR_US: begin
            r.command_kind = slcp_pkg::KIND_BITRATE;
            r.argument     = arg_nib;
            r.status       = (arg_nib >= rate_limit);
         end
         slcp_pkg::CHAR_LM, slcp_pkg::CHAR_UM: begin
            r.command_kind = slcp_pkg::KIND_MODE;
            r.argument     = {7'd0, arg_nib == 8'd1};
         end
         slcp_pkg::CHAR_LA, slcp_pkg::CHAR_UA: begin
            r.command_kind = slcp_pkg::KIND_AUTORETRY;
            r.argument     = {7'd0, arg_nib == 8'd1};
         end
         slcp_pkg::CHAR_UV: r.command_kind = slcp_pkg::KIND_VERSION;
         slcp_pkg::CHAR_UE: r.command_kind = slcp_pkg::KIND_ERROR_RPT;
         slcp_pkg::CHAR_LT, slcp_pkg::CHAR_UT, slcp_pkg::CHAR_LR, slcp_pkg::CHAR_UR: begin
            id_len = wide_id(cmd_letter) ? slcp_pkg::EXT_ID_NIBBLES
                                         : slcp_pkg::STD_ID_NIBBLES;
            got    = (char_pos < id_len) ? char_pos : id_len;
            r.command_kind = slcp_pkg::KIND_TRANSMIT;
            r.extended_id  = wide_id(cmd_letter);
            r.remote_frame = (cmd_letter == slcp_pkg::CHAR_LR) ||
                             (cmd_letter == slcp_pkg::CHAR_UR);
            // identifier nibbles that never came still shift it up
            r.identifier   = id_acc << (4 * (id_len - got));
            if (dlc_code > 8'(slcp_pkg::MAX_DATA_BYTES)) begin
               r.status = 1'b1;
            end else begin
               mask = (dlc_code >= 8'd8) ? '1 : (64'd1 << (8 * dlc_code)) - 64'd1;
               r.data_length = dlc_code[3:0];
               r.payload     = data_acc & mask;
            end
         end
         default: r.status = 1'b1;
      endcase
      return r;
   endfunction

   // fold one accepted request into the line state
   function automatic void parse_char(input logic [7:0] c, input logic last);
      logic [7:0] nib;
      logic [4:0] id_len;
      logic [7:0] data_byte;
      int k;
      if (char_pos == 5'd0) begin
         cmd_letter = c;
      end else begin
         nib = hex_value(c);
         if (char_pos == 5'd1)
            arg_nib = nib;
         id_len = wide_id(cmd_letter) ? slcp_pkg::EXT_ID_NIBBLES : slcp_pkg::STD_ID_NIBBLES;
         if (char_pos <= id_len) begin
            id_acc = (id_acc << 4) + {24'd0, nib};
         end else if (char_pos == id_len + 5'd1) begin
            dlc_code = nib;
         end else begin
            k = int'(char_pos) - int'(id_len) - 2;
            if (k < 2 * slcp_pkg::MAX_DATA_BYTES) begin
               if (k[0] == 1'b0) begin
                  hi_nib    = nib;
                  data_byte = {nib[3:0], 4'h0};
               end else begin
                  data_byte = {hi_nib[3:0], 4'h0} + nib;
               end
               data_acc[8 * (k / 2) +: 8] = data_byte;
            end
         end
      end
      if (last) begin
         parsed_commands.push_back(finish_command());
         clear_line();
      end else if (char_pos != slcp_pkg::POS_MAX) begin
         char_pos = char_pos + 5'd1;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
   endtask

   // request driver: holds a byte until taken, idles at random
   always @(posedge clock) begin : drive_requests
      line_char_type next_char;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            parse_char(req_chan.char_byte, req_chan.line_end);
         if (!req_chan.valid || req_chan.ready) begin
            if (line_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_char = line_bytes.pop_front();
               req_chan.valid     <= 1'b1;
               req_chan.char_byte <= next_char.code;
               req_chan.line_end  <= next_char.last;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: checks every field against the oldest prediction
   always @(posedge clock) begin : check_responses
      slcp_pkg::rsp_data_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (parsed_commands.size() == 0) begin
               report_mismatch("unexpected response", '0, '0);
            end else begin
               want = parsed_commands.pop_front();
               if (rsp_chan.status !== want.status)
                  report_mismatch("status", 64'(rsp_chan.status), 64'(want.status));
               if (rsp_chan.command_kind !== want.command_kind)
                  report_mismatch("command_kind", 64'(rsp_chan.command_kind),
                                  64'(want.command_kind));
               if (rsp_chan.extended_id !== want.extended_id)
                  report_mismatch("extended_id", 64'(rsp_chan.extended_id),
                                  64'(want.extended_id));
               if (rsp_chan.remote_frame !== want.remote_frame)
                  report_mismatch("remote_frame", 64'(rsp_chan.remote_frame),
                                  64'(want.remote_frame));
               if (rsp_chan.identifier !== want.identifier)
                  report_mismatch("identifier", 64'(rsp_chan.identifier),
                                  64'(want.identifier));
               if (rsp_chan.data_length !== want.data_length)
                  report_mismatch("data_length", 64'(rsp_chan.data_length),
                                  64'(want.data_length));
               if (rsp_chan.payload !== want.payload)
                  report_mismatch("payload", rsp_chan.payload, want.payload);
               if (rsp_chan.argument !== want.argument)
                  report_mismatch("argument", 64'(rsp_chan.argument), 64'(want.argument));
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic push_char(input logic [7:0] c, input logic last);
      line_char_type item;
      item.code = c;
      item.last = last;
      line_bytes.push_back(item);
   endtask

   task automatic push_line(input logic [7:0] text[$]);
      foreach (text[i])
         push_char(text[i], i == text.size() - 1);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10)
         return slcp_pkg::CHAR_ZERO + n;
      return ($urandom_range(1) ? slcp_pkg::CHAR_LA : slcp_pkg::CHAR_UA) + n - 8'd10;
   endfunction

   // mostly hex digits, now and then any byte
   function automatic logic [7:0] content_char();
      if ($urandom_range(19) == 0)
         return 8'($urandom_range(255));
      return hex_char(4'($urandom_range(15)));
   endfunction

   // one random command line; counted is the number of bytes queued
   task automatic add_random_line(output int counted);
      logic [7:0] text[$];
      logic [7:0] letter;
      int pick;
      int dlc;
      pick = $urandom_range(99);
      if (pick < 55) begin
         // frame with random content, sometimes cut short or run long
         case ($urandom_range(3))
            0: letter = slcp_pkg::CHAR_LT;
            1: letter = slcp_pkg::CHAR_UT;
            2: letter = slcp_pkg::CHAR_LR;
            default: letter = slcp_pkg::CHAR_UR;
         endcase
         text.push_back(letter);
         repeat (wide_id(letter) ? slcp_pkg::EXT_ID_NIBBLES : slcp_pkg::STD_ID_NIBBLES)
            text.push_back(content_char());
         dlc = ($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
         text.push_back(hex_char(4'(dlc)));
         if (dlc <= slcp_pkg::MAX_DATA_BYTES)
            repeat (2 * dlc) text.push_back(content_char());
         case ($urandom_range(9))
            0: begin
               pick = $urandom_range(text.size() - 1);
               while (text.size() > pick + 1)
                  void'(text.pop_back());
            end
            1: repeat ($urandom_range(20, 1)) text.push_back(8'($urandom_range(255)));
            default: ;
         endcase
      end else if (pick < 65) begin
         // bitrate index, often near the limit
         text.push_back(slcp_pkg::CHAR_US);
         if ($urandom_range(9) != 0)
            text.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                                   : hex_char(4'($urandom_range(15))));
      end else if (pick < 75) begin
         // silent mode and autoretry flags
         case ($urandom_range(3))
            0: letter = slcp_pkg::CHAR_LM;
            1: letter = slcp_pkg::CHAR_UM;
            2: letter = slcp_pkg::CHAR_LA;
            default: letter = slcp_pkg::CHAR_UA;
         endcase
         text.push_back(letter);
         case ($urandom_range(4))
            0: text.push_back(slcp_pkg::CHAR_ZERO);
            1: text.push_back(slcp_pkg::CHAR_ZERO + 8'd1);
            2: text.push_back(content_char());
            3: text.push_back(8'($urandom_range(255)));
            default: ;
         endcase
      end else if (pick < 85) begin
         // argument-free commands, sometimes with trailing bytes
         case ($urandom_range(3))
            0: letter = slcp_pkg::CHAR_UO;
            1: letter = slcp_pkg::CHAR_UC;
            2: letter = slcp_pkg::CHAR_UV;
            default: letter = slcp_pkg::CHAR_UE;
         endcase
         text.push_back(letter);
         if ($urandom_range(4) == 0)
            repeat ($urandom_range(3, 1)) text.push_back(content_char());
      end else if (pick < 92) begin
         // any letter, mostly unknown ones
         repeat ($urandom_range(5, 1)) text.push_back(8'($urandom_range(255)));
      end else begin
         // noise lines, some long enough to saturate the position
         repeat ($urandom_range(40, 1)) text.push_back(8'($urandom_range(255)));
      end
      counted = text.size();
      push_line(text);
   endtask

   task automatic run_random(input int target);
      int done;
      int n;
      done = 0;
      while (done < target) begin
         add_random_line(n);
         done += n;
      end
   endtask

   // sender holds off until every response is back and the pipe is empty
   task automatic wait_idle();
      while (line_bytes.size() != 0 || req_chan.valid || parsed_commands.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [7:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      rate_limit = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // stimulus
   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_chan.valid     = 1'b0;
      req_chan.char_byte = '0;
      req_chan.line_end  = 1'b0;
      rsp_chan.ready     = 1'b0;
      mismatch_count     = 0;
      idle_cycles        = 0;
      send_idle_pct      = 28;
      recv_idle_pct      = 61;
      rate_limit         = slcp_pkg::LIMIT_RESET;
      clear_line();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed lines: plain commands, flags, bad index and unknown letter
      push_char(slcp_pkg::CHAR_UO, 1'b1);
      push_char(slcp_pkg::CHAR_UC, 1'b1);
      push_char(slcp_pkg::CHAR_UV, 1'b1);
      push_char(slcp_pkg::CHAR_UE, 1'b1);
      push_char(slcp_pkg::CHAR_US, 1'b0);
      push_char(slcp_pkg::CHAR_ZERO + 8'd9, 1'b1);
      push_char(slcp_pkg::CHAR_UM, 1'b0);
      push_char(slcp_pkg::CHAR_ZERO + 8'd1, 1'b1);
      push_char(slcp_pkg::CHAR_LA, 1'b0);
      push_char(slcp_pkg::CHAR_ZERO, 1'b1);
      push_char(8'hFF, 1'b1);
      // bare frame letter, then a short extended frame with wrapping nibbles
      push_char(slcp_pkg::CHAR_LT, 1'b1);
      push_char(slcp_pkg::CHAR_UR, 1'b0);
      push_char(8'h00, 1'b0);
      push_char(8'hFF, 1'b1);
      // remote frame with a length code above eight
      push_char(slcp_pkg::CHAR_LR, 1'b0);
      push_char(slcp_pkg::CHAR_ZERO + 8'd7, 1'b0);
      push_char(slcp_pkg::CHAR_UA + 8'd5, 1'b0);
      push_char(slcp_pkg::CHAR_LA + 8'd5, 1'b0);
      push_char(slcp_pkg::CHAR_ZERO + 8'd9, 1'b1);
      // full standard frame with one data byte
      push_char(slcp_pkg::CHAR_LT, 1'b0);
      push_char(slcp_pkg::CHAR_ZERO + 8'd1, 1'b0);
      push_char(slcp_pkg::CHAR_ZERO + 8'd2, 1'b0);
      push_char(slcp_pkg::CHAR_ZERO + 8'd3, 1'b0);
      push_char(slcp_pkg::CHAR_ZERO + 8'd1, 1'b0);
      push_char(slcp_pkg::CHAR_UA, 1'b0);
      push_char(slcp_pkg::CHAR_ZERO + 8'd5, 1'b1);

      run_random(400);
      wait_idle();

      write_limit(8'd255);
      run_random(250);
      wait_idle();

      send_idle_pct = 61;
      recv_idle_pct = 28;
      write_limit(8'd0);
      run_random(250);
      wait_idle();

      write_limit(8'd1);
      run_random(250);
      wait_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_limit(8'($urandom_range(254, 2)));
      run_random(400);
      wait_idle();

      repeat (6) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* files.f */
rtl/core/slcp_pkg.sv
rtl/core/slcp_if.sv
rtl/core/slcp_finish.sv
rtl/core/slcan_command_line_parser.sv
tb/tb_slcan_command_line_parser.sv
